[src/mfb_pkg.sv]
`default_nettype none
package mfb_pkg;

	// Canvas limits and derived store geometry
	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int ROW_MAX     = (MAX_WIDTH + 7) / 8;
	localparam int STORE_BYTES = ROW_MAX * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int CNT_W       = $clog2(STORE_BYTES + 1);
	localparam int ROW_W       = $clog2(ROW_MAX + 1);

	// Fixed field widths
	localparam int DIM_W  = 9;
	localparam int POS_W  = 8;
	localparam int IDX_W  = 13;
	localparam int PROD_W = ROW_W + DIM_W;

	// Configuration register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;

	typedef enum logic [2:0] {
		CMD_SET_PIXEL = 3'd0,
		CMD_GET_PIXEL = 3'd1,
		CMD_VLINE     = 3'd2,
		CMD_FILL      = 3'd3,
		CMD_INVERT    = 3'd4,
		CMD_READ_BYTE = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_MODIFY,
		ST_FILL,
		ST_FINISH
	} state_t;

	// Frame store port request
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage
`default_nettype wire

[src/mono_framebuffer_engine_top.sv]
`default_nettype none
// Channel    Dir  Handshake                     Payload
// s_axis     in   s_axis_tvalid/s_axis_tready   tuser cmd, tdata pixel/line/index fields
// m_axis     out  m_axis_tvalid/m_axis_tready   tuser status, tdata pixel and byte value
// cfg        in   cfg_valid/cfg_ready           cfg_index, cfg_data (width, height)
//
// Per request: set, get and read byte pass through decode, read, modify and finish once;
// vertical line reads and writes back each row; fill writes each active byte; invert reads, then
// writes back each active byte. The frame store has one write port and one registered read port.
// After reset a clearing pass writes all STORE_BYTES (8192) bytes, one a cycle,
// with s_axis_tready low; cfg writes are taken throughout.
// A result waits in the output register; a finished request holds there until it is free.
module mono_framebuffer_engine_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,   // x_pos, y_pos, line_len, colour, byte_index, pad
	input  wire logic [2:0]  s_axis_tuser,   // cmd
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // pixel_value, byte_value, pad
	output logic             m_axis_tuser,   // status
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [8:0]  cfg_data
);
	import mfb_pkg::*;

	state_t state_q, state_d;

	logic [DIM_W-1:0]  width_q, height_q;
	cmd_t              cmd_q;
	logic [POS_W-1:0]  x_q, y_q;
	logic [DIM_W-1:0]  len_q;
	logic              colour_q;
	logic [IDX_W-1:0]  idx_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pix_q, status_q;
	logic [7:0]        byte_q;
	logic              out_valid_q, out_pix_q, out_status_q;
	logic [7:0]        out_byte_q;

	mem_req_t   mem_req;
	logic [7:0] rdata;

	// Effective canvas geometry
	logic [DIM_W-1:0]  eff_w, eff_h;
	logic [ROW_W-1:0]  row_bytes;
	logic [DIM_W:0]    w_round;

	assign eff_w     = (width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
	assign eff_h     = (height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;
	assign w_round   = {1'b0, eff_w} + (DIM_W+1)'(7);
	assign row_bytes = ROW_W'(w_round >> 3);

	// Shared multiply/add unit: row address or active byte count
	logic [DIM_W-1:0]  mul_b;
	logic [PROD_W-1:0] prod, pix_sum;
	logic              walk_cmd;

	assign walk_cmd = cmd_q inside {CMD_FILL, CMD_INVERT, CMD_READ_BYTE};
	assign mul_b    = walk_cmd ? eff_h : {1'b0, y_q};
	assign prod     = PROD_W'(row_bytes) * PROD_W'(mul_b);
	assign pix_sum  = prod + PROD_W'(x_q[POS_W-1:3]);

	// Bound checks and line clipping
	logic             in_canvas, idx_ok;
	logic [DIM_W-1:0] room, line_cnt;
	logic [7:0]       mask;

	assign in_canvas = ({1'b0, x_q} < eff_w) && ({1'b0, y_q} < eff_h);
	assign idx_ok    = PROD_W'(idx_q) < prod;
	assign room      = eff_h - {1'b0, y_q};
	assign line_cnt  = (len_q < room) ? len_q : room;
	assign mask      = 8'h80 >> x_q[2:0];

	// Address stepper
	logic [ADDR_W-1:0] step, addr_next;
	logic              last_step;

	assign step      = (state_q == ST_MODIFY && cmd_q == CMD_VLINE) ?
	                   ADDR_W'(row_bytes) : ADDR_W'(1);
	assign addr_next = addr_q + step;
	assign last_step = (cnt_q == CNT_W'(1));

	logic accept, out_free;
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (addr_q == ADDR_W'(STORE_BYTES - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (cmd_q)
					CMD_SET_PIXEL, CMD_GET_PIXEL:
						state_d = in_canvas ? ST_READ : ST_FINISH;
					CMD_VLINE:
						state_d = (in_canvas && line_cnt != '0) ? ST_READ : ST_FINISH;
					CMD_FILL:
						state_d = (prod != '0) ? ST_FILL : ST_FINISH;
					CMD_INVERT:
						state_d = (prod != '0) ? ST_READ : ST_FINISH;
					CMD_READ_BYTE:
						state_d = idx_ok ? ST_READ : ST_FINISH;
					default:
						state_d = ST_FINISH;
				endcase
			end
			ST_READ: begin
				state_d = ST_MODIFY;
			end
			ST_MODIFY: begin
				if (cmd_q inside {CMD_VLINE, CMD_INVERT}) begin
					state_d = last_step ? ST_FINISH : ST_READ;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FILL: begin
				if (last_step) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: handshake and store port
	always_comb begin
		s_axis_tready = 1'b0;
		mem_req       = '0;
		mem_req.waddr = addr_q;
		mem_req.raddr = addr_q;
		case (state_q)
			ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = 8'h00;
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_READ: begin
				mem_req.re = 1'b1;
			end
			ST_MODIFY: begin
				case (cmd_q)
					CMD_SET_PIXEL, CMD_VLINE: begin
						mem_req.we    = 1'b1;
						mem_req.wdata = colour_q ? (rdata | mask) : (rdata & ~mask);
					end
					CMD_INVERT: begin
						mem_req.we    = 1'b1;
						mem_req.wdata = ~rdata;
					end
					default: mem_req.we = 1'b0;
				endcase
			end
			ST_FILL: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = colour_q ? 8'hFF : 8'h00;
			end
			default: s_axis_tready = 1'b0;
		endcase
	end

	// State and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			width_q  <= DIM_W'(256);
			height_q <= DIM_W'(256);
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_WIDTH)  width_q  <= cfg_data;
				if (cfg_index == REG_HEIGHT) height_q <= cfg_data;
			end
		end
	end

	assign cfg_ready = 1'b1;

	// Address and count (also the clearing sweep)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			cnt_q  <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: addr_q <= addr_next;
				ST_DECODE: begin
					case (cmd_q)
						CMD_SET_PIXEL, CMD_GET_PIXEL: addr_q <= ADDR_W'(pix_sum);
						CMD_VLINE: begin
							addr_q <= ADDR_W'(pix_sum);
							cnt_q  <= CNT_W'(line_cnt);
						end
						CMD_FILL, CMD_INVERT: begin
							addr_q <= '0;
							cnt_q  <= CNT_W'(prod);
						end
						CMD_READ_BYTE: addr_q <= ADDR_W'(idx_q);
						default: cnt_q <= '0;
					endcase
				end
				ST_MODIFY, ST_FILL: begin
					addr_q <= addr_next;
					cnt_q  <= cnt_q - CNT_W'(1);
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Request capture and result collection
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd_t'(s_axis_tuser);
			x_q      <= s_axis_tdata[7:0];
			y_q      <= s_axis_tdata[15:8];
			len_q    <= s_axis_tdata[24:16];
			colour_q <= s_axis_tdata[25];
			idx_q    <= s_axis_tdata[38:26];
			pix_q    <= 1'b0;
			byte_q   <= 8'h00;
			status_q <= 1'b0;
		end
		if (state_q == ST_DECODE) begin
			case (cmd_q)
				CMD_SET_PIXEL, CMD_GET_PIXEL, CMD_VLINE: status_q <= !in_canvas;
				CMD_FILL, CMD_INVERT:                    status_q <= 1'b0;
				CMD_READ_BYTE:                           status_q <= !idx_ok;
				default:                                 status_q <= 1'b1;
			endcase
		end
		if (state_q == ST_MODIFY) begin
			if (cmd_q == CMD_GET_PIXEL) pix_q  <= |(rdata & mask);
			if (cmd_q == CMD_READ_BYTE) byte_q <= rdata;
		end
		if (state_q == ST_FINISH && out_free) begin
			out_pix_q    <= pix_q;
			out_byte_q   <= byte_q;
			out_status_q <= status_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_byte_q, out_pix_q};
	assign m_axis_tuser  = out_status_q;

	mfb_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	// Checks
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_DECODE))
		else $error("accepted request did not enter decode");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> (state_q == ST_CLEAR || state_q == ST_MODIFY || state_q == ST_FILL))
		else $error("store written outside a write state");

	a_walk_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL || (state_q == ST_MODIFY && cmd_q == CMD_INVERT)) |->
		(cnt_q != '0))
		else $error("byte walk with empty count");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(state_q) == ST_FINISH))
		else $error("result raised outside finish");

endmodule
`default_nettype wire

[src/mfb_store.sv]
`default_nettype none
module mfb_store (
	input  wire logic              clk,
	input  wire mfb_pkg::mem_req_t req,
	output logic [7:0]             rdata
);
	import mfb_pkg::*;

	logic [7:0] mem [STORE_BYTES];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule
`default_nettype wire
